FILE: rtl/byte_histogram_engine_top_assert.svh
// ----------------------------------------------------------------------------
// byte histogram engine assertion macros
// immediate-style wrappers around concurrent properties, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef BYTE_HISTOGRAM_ENGINE_TOP_ASSERT_SVH
`define BYTE_HISTOGRAM_ENGINE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BHE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bhe assertion failed");

// next-cycle implication
`define BHE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bhe assertion failed");

`else

`define BHE_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define BHE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/bhe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhe_pkg
// shared types and constants of the byte histogram engine
// ----------------------------------------------------------------------------
package bhe_pkg;

    localparam int SYMBOL_BITS_DEF = 8;
    localparam int COUNT_BITS_DEF  = 32;

    localparam int MODE_BITS      = 2;
    localparam int IN_SYM_BITS    = 8;
    localparam int BIN_OUT_BITS   = 32;
    localparam int TOTAL_BITS     = 40;
    localparam int HIGH_OUT_BITS  = 8;
    localparam int OUT_DATA_BITS  = BIN_OUT_BITS + TOTAL_BITS + HIGH_OUT_BITS;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_COUNT = 2'd0,
        MODE_READ  = 2'd1,
        MODE_CLEAR = 2'd2
    } t_mode;

    // controller to datapath
    typedef struct packed {
        logic accept;    // input beat taken, issue bin read
        logic cnt_wr;    // write incremented bin, update tracking
        logic clr_wr;    // write zero at sweep pointer, reset tracking
        logic out_load;  // load result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;  // sweep pointer at last bin
        logic out_free;  // result register can take a new beat
    } t_sts;

endpackage

FILE: rtl/bhe_ctrl.sv
`timescale 1ns / 1ps
`include "byte_histogram_engine_top_assert.svh"
// ----------------------------------------------------------------------------
// bhe_ctrl
// item sequencer: clear sweep, accept, execute
// ----------------------------------------------------------------------------
module bhe_ctrl
    import bhe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic [MODE_BITS-1:0] i_s_tuser,
    output logic                 o_s_tready,
    input  t_sts                 i_sts,
    output t_cmd                 o_cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state, n_state;
    t_mode  r_mode,  n_mode;
    logic   accept;
    t_mode  in_mode;

    assign in_mode    = t_mode'(i_s_tuser);
    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = o_s_tready && i_s_tvalid;

    always_comb begin
        n_state        = r_state;
        n_mode         = r_mode;
        o_cmd          = '0;
        o_cmd.accept   = accept;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_mode = in_mode;
                    case (in_mode) inside
                        MODE_COUNT, MODE_READ: n_state = S_EXEC;
                        MODE_CLEAR:            n_state = S_CLEAR;
                        default:               n_state = S_IDLE;  // unused code dropped
                    endcase
                end
            end
            S_EXEC: begin
                if (r_mode == MODE_READ) begin
                    // hold the fetched bin until the result register frees up
                    if (i_sts.out_free) begin
                        o_cmd.out_load = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else begin
                    o_cmd.cnt_wr = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_mode  <= MODE_COUNT;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

    `BHE_ASSERT_SAME(a_load_needs_room, i_clk, i_rst_n, o_cmd.out_load, i_sts.out_free)
    `BHE_ASSERT_NEXT(a_count_returns, i_clk, i_rst_n, o_cmd.cnt_wr, r_state == S_IDLE)
    `BHE_ASSERT_SAME(a_single_write, i_clk, i_rst_n, o_cmd.clr_wr, !o_cmd.cnt_wr && !o_s_tready)

endmodule

FILE: rtl/bhe_datapath.sv
`timescale 1ns / 1ps
`include "byte_histogram_engine_top_assert.svh"
// ----------------------------------------------------------------------------
// bhe_datapath
// bin memory, saturating counters, tracking registers and result register
// ----------------------------------------------------------------------------
module bhe_datapath
    import bhe_pkg::*;
#(
    parameter int SYMBOL_BITS = SYMBOL_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic [IN_SYM_BITS-1:0]   i_s_tdata,
    input  logic                     i_m_tready,
    output t_sts                     o_sts,
    output logic                     o_m_tvalid,
    output logic [OUT_DATA_BITS-1:0] o_m_tdata,
    output logic [0:0]               o_m_tuser
);

    localparam int NumBins = 1 << SYMBOL_BITS;

    logic [COUNT_BITS-1:0]  r_bins [NumBins];
    logic [COUNT_BITS-1:0]  r_rdata;
    logic [SYMBOL_BITS-1:0] r_sym;
    logic [SYMBOL_BITS-1:0] r_ptr;
    logic [TOTAL_BITS-1:0]  r_total;
    logic [SYMBOL_BITS-1:0] r_top;
    logic                   r_seen;
    logic                   r_out_valid;
    logic [OUT_DATA_BITS-1:0] r_out_data;
    logic                   r_out_user;

    logic [SYMBOL_BITS+IN_SYM_BITS-1:0]  sym_wide;
    logic [SYMBOL_BITS-1:0]              in_sym;
    logic [COUNT_BITS+BIN_OUT_BITS-1:0]  bin_wide;
    logic [SYMBOL_BITS+HIGH_OUT_BITS-1:0] top_wide;
    logic [COUNT_BITS-1:0]  bin_inc;
    logic                   wr_en;
    logic [SYMBOL_BITS-1:0] wr_addr;
    logic [COUNT_BITS-1:0]  wr_data;

    // symbol folded into the bin range, zero-extended when bins outnumber bytes
    assign sym_wide = {{SYMBOL_BITS{1'b0}}, i_s_tdata};
    assign in_sym   = sym_wide[SYMBOL_BITS-1:0];

    assign bin_inc  = (&r_rdata) ? r_rdata : r_rdata + COUNT_BITS'(1);
    assign bin_wide = {{BIN_OUT_BITS{1'b0}}, r_rdata};
    assign top_wide = {{HIGH_OUT_BITS{1'b0}}, r_top};

    assign wr_en   = i_cmd.clr_wr || i_cmd.cnt_wr;
    assign wr_addr = i_cmd.clr_wr ? r_ptr : r_sym;
    assign wr_data = i_cmd.clr_wr ? '0 : bin_inc;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_bins[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rdata <= r_bins[in_sym];
            r_sym   <= in_sym;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr   <= '0;
            r_total <= '0;
            r_top   <= '0;
            r_seen  <= 1'b0;
        end else if (i_cmd.clr_wr) begin
            r_ptr   <= r_ptr + SYMBOL_BITS'(1);  // wraps to zero after last bin
            r_total <= '0;
            r_top   <= '0;
            r_seen  <= 1'b0;
        end else if (i_cmd.cnt_wr) begin
            if (!(&r_total)) begin
                r_total <= r_total + TOTAL_BITS'(1);
            end
            if (!r_seen || (r_sym > r_top)) begin
                r_top <= r_sym;
            end
            r_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {top_wide[HIGH_OUT_BITS-1:0], r_total,
                           bin_wide[BIN_OUT_BITS-1:0]};
            r_out_user <= r_seen;
        end
    end

    assign o_sts.clr_last = &r_ptr;
    assign o_sts.out_free = !r_out_valid || i_m_tready;

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = r_out_data;
    assign o_m_tuser[0] = r_out_user;

    `BHE_ASSERT_SAME(a_top_zero_unseen, i_clk, i_rst_n, !r_seen, r_top == '0)
    `BHE_ASSERT_NEXT(a_count_sets_seen, i_clk, i_rst_n, i_cmd.cnt_wr, r_seen)
    `BHE_ASSERT_NEXT(a_total_saturates, i_clk, i_rst_n,
                     (&r_total) && !i_cmd.clr_wr, &r_total)

endmodule

FILE: rtl/byte_histogram_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_histogram_engine_top
// 2^SYMBOL_BITS saturating byte counters with running total and top symbol
// ----------------------------------------------------------------------------
// input stream: s_tuser carries the item kind (count, read, clear), s_tdata
//   the byte to count or the bin to read. an unused kind is taken and dropped.
// output stream: one beat per read item with the bin count, the saturating
//   40-bit total, the highest byte counted and an any-seen flag in tuser.
// count item: the bin is read at accept, then incremented and written back
//   through the single write port before the next item is accepted.
// read item: the bin is read at accept and loaded into the result register
//   in the execute step; no new item is accepted before that load.
// clear item: sweeps every bin, one per cycle; s_tready stays low until the
//   sweep has passed the last bin.
// reset: the same sweep runs after reset, with s_tready low until it ends.
// output stall: a finished result sits in the output register, so new count
//   and clear items are still taken; a following read waits in its execute
//   step, bin already fetched, until the held beat leaves.
// ----------------------------------------------------------------------------
module byte_histogram_engine_top
    import bhe_pkg::*;
#(
    parameter int SYMBOL_BITS = SYMBOL_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_SYM_BITS-1:0]   s_tdata,   // [7:0] symbol
    input  logic [MODE_BITS-1:0]     s_tuser,   // [1:0] mode
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_DATA_BITS-1:0] m_tdata,   // [31:0] bin_count, [71:32] total_count,
                                                // [79:72] highest_symbol
    output logic [0:0]               m_tuser    // [0] any_seen
);

    t_cmd cmd;
    t_sts sts;

    bhe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tuser  (s_tuser),
        .o_s_tready (s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bhe_datapath #(
        .SYMBOL_BITS (SYMBOL_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_s_tdata  (s_tdata),
        .i_m_tready (m_tready),
        .o_sts      (sts),
        .o_m_tvalid (m_tvalid),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the byte histogram engine: a directed table of count,
// read, clear and unused-kind beats, then random traffic; every read result is
// checked against a typed value or an in-bench histogram kept in step with accepts
// ----------------------------------------------------------------------------
module tb;
    import bhe_pkg::*;

    localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;
    localparam int NUM_BINS       = 1 << SYMBOL_BITS_DEF;
    localparam int DIR_ROWS       = 25;
    localparam int RAND_ITEMS     = 1400;
    localparam int QUIET_ITEMS    = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [BIN_OUT_BITS-1:0]  bin_count;
        logic [TOTAL_BITS-1:0]    total_count;
        logic [HIGH_OUT_BITS-1:0] highest_symbol;
        logic                     any_seen;
    } t_result;

    typedef struct packed {
        logic [MODE_BITS-1:0]   mode;
        logic [IN_SYM_BITS-1:0] sym;
        logic                   typed;
        t_result                want;
    } t_stim_row;

    logic                     i_clk    = 1'b0;
    logic                     i_rst_n  = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_SYM_BITS-1:0]   s_tdata  = '0;   // [7:0] symbol
    logic [MODE_BITS-1:0]     s_tuser  = '0;   // [1:0] mode
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;         // [31:0] bin_count, [71:32] total_count,
                                               // [79:72] highest_symbol
    logic [0:0]               m_tuser;         // [0] any_seen

    byte_histogram_engine_top DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // histogram kept by the bench
    logic [COUNT_BITS_DEF-1:0]  bin_cnt [NUM_BINS];
    logic [TOTAL_BITS-1:0]      total_cnt;
    logic [SYMBOL_BITS_DEF-1:0] top_sym;
    logic                       seen;

    t_result read_q [$];
    int      mismatches  = 0;
    int      idle_pct    = 0;
    int      stall_pct   = 0;
    int      stall_left  = 0;
    int      idle_cycles = 0;
    t_result got_beat;
    t_result want_beat;

    // expected values typed in only where they follow at a glance
    t_stim_row dir_rows [DIR_ROWS] = '{
        '{MODE_READ,   8'h00, 1'b1, '{32'd0, 40'd0, 8'h00, 1'b0}},
        '{MODE_READ,   8'hFF, 1'b1, '{32'd0, 40'd0, 8'h00, 1'b0}},
        '{MODE_COUNT,  8'hFF, 1'b0, '0},
        '{MODE_READ,   8'hFF, 1'b1, '{32'd1, 40'd1, 8'hFF, 1'b1}},
        '{MODE_COUNT,  8'h00, 1'b0, '0},
        '{MODE_READ,   8'h00, 1'b1, '{32'd1, 40'd2, 8'hFF, 1'b1}},
        '{MODE_UNUSED, 8'h07, 1'b0, '0},
        '{MODE_READ,   8'h07, 1'b1, '{32'd0, 40'd2, 8'hFF, 1'b1}},
        '{MODE_UNUSED, 8'hFF, 1'b0, '0},
        '{MODE_CLEAR,  8'hAA, 1'b0, '0},
        '{MODE_READ,   8'hFF, 1'b1, '{32'd0, 40'd0, 8'h00, 1'b0}},
        '{MODE_COUNT,  8'h00, 1'b0, '0},
        '{MODE_READ,   8'h00, 1'b1, '{32'd1, 40'd1, 8'h00, 1'b1}},
        '{MODE_COUNT,  8'h80, 1'b0, '0},
        '{MODE_COUNT,  8'h80, 1'b0, '0},
        '{MODE_READ,   8'h80, 1'b1, '{32'd2, 40'd3, 8'h80, 1'b1}},
        '{MODE_COUNT,  8'h7F, 1'b0, '0},
        '{MODE_READ,   8'h7F, 1'b1, '{32'd1, 40'd4, 8'h80, 1'b1}},
        '{MODE_COUNT,  8'h55, 1'b0, '0},
        '{MODE_READ,   8'h55, 1'b0, '0},
        '{MODE_READ,   8'h55, 1'b0, '0},
        '{MODE_COUNT,  8'hAA, 1'b0, '0},
        '{MODE_READ,   8'hAA, 1'b0, '0},
        '{MODE_CLEAR,  8'h00, 1'b0, '0},
        '{MODE_READ,   8'h80, 1'b1, '{32'd0, 40'd0, 8'h00, 1'b0}}
    };

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_histogram();
        for (int b = 0; b < NUM_BINS; b++) begin
            bin_cnt[b] = '0;
        end
        total_cnt = '0;
        top_sym   = '0;
        seen      = 1'b0;
    endfunction

    function automatic void histogram_step(input logic [MODE_BITS-1:0] mode,
                                           input logic [IN_SYM_BITS-1:0] sym,
                                           output bit has_read, output t_result rd);
        logic [SYMBOL_BITS_DEF-1:0] idx;
        idx      = sym[SYMBOL_BITS_DEF-1:0];
        has_read = 1'b0;
        rd       = '0;
        case (mode)
            MODE_COUNT: begin
                if (bin_cnt[idx] != '1) bin_cnt[idx] = bin_cnt[idx] + COUNT_BITS_DEF'(1);
                if (total_cnt != '1) total_cnt = total_cnt + TOTAL_BITS'(1);
                if (!seen || idx > top_sym) top_sym = idx;
                seen = 1'b1;
            end
            MODE_READ: begin
                has_read          = 1'b1;
                rd.bin_count      = BIN_OUT_BITS'(bin_cnt[idx]);
                rd.total_count    = total_cnt;
                rd.highest_symbol = HIGH_OUT_BITS'(top_sym);
                rd.any_seen       = seen;
            end
            MODE_CLEAR: begin
                clear_histogram();
            end
            default: ;
        endcase
    endfunction

    task automatic send_item(input logic [MODE_BITS-1:0] mode, input logic [IN_SYM_BITS-1:0] sym,
                             input logic typed, input t_result typed_want);
        t_result pred;
        bit      has_read;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= sym;
        do @(posedge i_clk); while (!s_tready);
        histogram_step(mode, sym, has_read, pred);
        if (has_read) read_q.push_back(typed ? typed_want : pred);
    endtask

    // output side back-pressure in bursts
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left <= $urandom_range(0, 5);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result beat check
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            got_beat.bin_count      = m_tdata[31:0];
            got_beat.total_count    = m_tdata[71:32];
            got_beat.highest_symbol = m_tdata[79:72];
            got_beat.any_seen       = m_tuser[0];
            if (read_q.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected result beat: bin %0d total %0d high %0d seen %0b",
                             got_beat.bin_count, got_beat.total_count,
                             got_beat.highest_symbol, got_beat.any_seen);
                mismatches++;
            end else begin
                want_beat = read_q.pop_front();
                if (got_beat.bin_count !== want_beat.bin_count
                        || got_beat.total_count !== want_beat.total_count
                        || got_beat.highest_symbol !== want_beat.highest_symbol
                        || got_beat.any_seen !== want_beat.any_seen) begin
                    if (mismatches < MAX_REPORTS)
                        $display("result mismatch: exp bin %0d total %0d high %0d seen %0b, %s",
                                 want_beat.bin_count, want_beat.total_count,
                                 want_beat.highest_symbol, want_beat.any_seen,
                                 $sformatf("got bin %0d total %0d high %0d seen %0b",
                                           got_beat.bin_count, got_beat.total_count,
                                           got_beat.highest_symbol, got_beat.any_seen));
                    mismatches++;
                end
            end
        end
    end

    // a clear sweep holds off input for far less time than the watchdog limit
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [MODE_BITS-1:0]   md;
        logic [IN_SYM_BITS-1:0] sy;
        logic [IN_SYM_BITS-1:0] last_counted;
        logic [IN_SYM_BITS-1:0] focus_base;
        bit                     focused;
        int                     pick;
        last_counted = '0;
        focus_base   = '0;
        focused      = 1'b0;
        clear_histogram();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            send_item(dir_rows[r].mode, dir_rows[r].sym, dir_rows[r].typed, dir_rows[r].want);
        end

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 64 == 0) begin
                if (n >= RAND_ITEMS - QUIET_ITEMS) begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end else begin
                    idle_pct   = 25 * $urandom_range(0, 2);
                    stall_pct  = 25 * $urandom_range(0, 2);
                    focused    = 1'($urandom_range(0, 1));
                    focus_base = IN_SYM_BITS'($urandom_range(0, 255));
                end
            end
            // four hot bins build counts and hit back-to-back updates of one bin
            sy   = focused ? focus_base + IN_SYM_BITS'($urandom_range(0, 3))
                           : IN_SYM_BITS'($urandom_range(0, 255));
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                md = MODE_CLEAR;
            end else if (pick < 5) begin
                md = MODE_UNUSED;
            end else if (pick < 60) begin
                md           = MODE_COUNT;
                last_counted = sy;
            end else begin
                md = MODE_READ;
                if ($urandom_range(0, 1) == 1) sy = last_counted;
            end
            send_item(md, sy, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (read_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/bhe_pkg.sv
rtl/bhe_ctrl.sv
rtl/bhe_datapath.sv
rtl/byte_histogram_engine_top.sv
tb/sv/tb.sv
